FILE: hdl/vcfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and helper functions for the voxel chunk face culler.
// No dependencies; imported by vcfc_regs and voxel_chunk_face_culler_top.
package vcfc_pkg;

  // Chunk geometry.
  localparam int CHUNK_WIDTH  = 16;
  localparam int CHUNK_HEIGHT = 256;
  localparam int CELL_COUNT   = CHUNK_WIDTH * CHUNK_WIDTH * CHUNK_HEIGHT;
  localparam int ADDR_W       = $clog2(CELL_COUNT);

  // Field widths of a transaction.
  localparam int KIND_W   = 2;
  localparam int CX_W     = 4;
  localparam int CY_W     = 8;
  localparam int CZ_W     = 4;
  localparam int TYPE_W   = 3;
  localparam int DIR_W    = 3;
  localparam int TC_W     = 4;
  localparam int FC_W     = 19;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 48;

  localparam int NUM_TYPES  = 8;
  localparam int NUM_DIRS   = 6;
  localparam int TILE_W     = 24;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 2;
  localparam int APB_DW     = 32;

  localparam logic [FC_W-1:0] FACE_MAX = FC_W'(393215);

  // Transaction kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MESH  = 2'd2;

  // Face directions, in the order they are tested.
  localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd1;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd5;

  typedef logic [NUM_TYPES-1:0][TILE_W-1:0] tile_bank_t;

  // Reset value of the tile register for each block type.
  function automatic logic [TILE_W-1:0] tile_reset(input int idx);
    logic [TILE_W-1:0] v;
    case (idx)
      1:       v = TILE_W'(15921648);
      2:       v = TILE_W'(15921906);
      3:       v = TILE_W'(15987699);
      4:       v = TILE_W'(14934755);
      5:       v = TILE_W'(13027014);
      7:       v = TILE_W'(14737632);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic int step_dx(input logic [DIR_W-1:0] dir);
    int s;
    case (dir)
      DIR_PX:  s = 1;
      DIR_NX:  s = -1;
      default: s = 0;
    endcase
    return s;
  endfunction

  function automatic int step_dy(input logic [DIR_W-1:0] dir);
    int s;
    case (dir)
      DIR_PY:  s = 1;
      DIR_NY:  s = -1;
      default: s = 0;
    endcase
    return s;
  endfunction

  function automatic int step_dz(input logic [DIR_W-1:0] dir);
    int s;
    case (dir)
      DIR_NZ:  s = -1;
      DIR_PZ:  s = 1;
      default: s = 0;
    endcase
    return s;
  endfunction

  function automatic logic in_chunk(input int x, input int y, input int z);
    return (x >= 0) && (x < CHUNK_WIDTH) && (y >= 0) && (y < CHUNK_HEIGHT) &&
           (z >= 0) && (z < CHUNK_WIDTH);
  endfunction

  // Store layout: z fastest, then y, then x.
  function automatic logic [ADDR_W-1:0] cell_addr(input int x, input int y, input int z);
    return ADDR_W'((x * CHUNK_HEIGHT + y) * CHUNK_WIDTH + z);
  endfunction

endpackage

FILE: hdl/vcfc_regs.sv
`timescale 1ns / 1ps
// APB register file holding the per-type atlas tile coordinates.
// Depends on vcfc_pkg.
module vcfc_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vcfc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [vcfc_pkg::APB_DW-1:0]         pwdata,
  output logic [vcfc_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  output vcfc_pkg::tile_bank_t                tiles_o
);
  import vcfc_pkg::*;

  tile_bank_t             tiles_q;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = APB_DW'(tiles_q[reg_idx]);
  assign tiles_o = tiles_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        tiles_q[i] <= tile_reset(i);
      end
    end else if (wr_en) begin
      tiles_q[reg_idx] <= pwdata[TILE_W-1:0];
    end
  end

endmodule

FILE: hdl/voxel_chunk_face_culler_top.sv
`timescale 1ns / 1ps
// Voxel chunk face culler: block store with read-modify sequencer and face emitter.
// Depends on vcfc_pkg and vcfc_regs.
//
// Write and begin transactions complete as they are accepted and leave the block idle.
// A mesh transaction reads the cell and its six neighbors in turn (S_READ) through
// the single read port of the block store, collects the last read (S_WAIT), and
// then forms its results one at a time (S_EMIT); no new input transaction is taken
// until its last result has been registered.
// A result waits in the output register while the output is stalled, and the next
// result of the same mesh is not formed until it is taken, so a stall lengthens the
// mesh transaction.
// Reset: the block store is swept to air one cell per cycle over all CELL_COUNT
// cells (65536 for a 16 x 256 x 16 chunk); no input transaction is taken meanwhile,
// while configuration writes are. The face counter resets to zero and the tile
// registers to their default atlas coordinates.
module voxel_chunk_face_culler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: cell_x[3:0], cell_y[11:4], cell_z[15:12], block_type[18:16], zeros above.
  input  logic [vcfc_pkg::IN_DW-1:0]        s_axis_tdata,
  // tuser: kind[1:0].
  input  logic [vcfc_pkg::KIND_W-1:0]       s_axis_tuser,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: face_x[3:0], face_y[11:4], face_z[15:12], face_dir[18:16],
  //        tile_x[22:19], tile_y[26:23], face_number[45:27], zeros above.
  output logic [vcfc_pkg::OUT_DW-1:0]       m_axis_tdata,
  output logic                              m_axis_tlast,
  // tuser: visible[0].
  output logic                              m_axis_tuser,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vcfc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vcfc_pkg::APB_DW-1:0]       pwdata,
  output logic [vcfc_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import vcfc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WAIT,
    S_EMIT
  } state_e;

  // Configuration registers.
  tile_bank_t tiles;

  vcfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tiles_o (tiles)
  );

  // Input unpacking.
  logic [KIND_W-1:0] in_kind;
  logic [CX_W-1:0]   in_x;
  logic [CY_W-1:0]   in_y;
  logic [CZ_W-1:0]   in_z;
  logic [TYPE_W-1:0] in_type;
  logic              in_acc;

  assign in_kind = s_axis_tuser;
  assign in_x    = s_axis_tdata[3:0];
  assign in_y    = s_axis_tdata[11:4];
  assign in_z    = s_axis_tdata[15:12];
  assign in_type = s_axis_tdata[18:16];

  state_e               state_q;
  logic [ADDR_W-1:0]    clr_q;
  logic [CX_W-1:0]      x_q;
  logic [CY_W-1:0]      y_q;
  logic [CZ_W-1:0]      z_q;
  logic [2:0]           rd_q;       // 0 reads the cell itself, 1..6 the neighbors
  logic                 cap_vld_q;  // read data of the previous cycle is to be captured
  logic [2:0]           cap_idx_q;
  logic                 cap_inch_q;
  logic [TYPE_W-1:0]    self_q;
  logic [NUM_DIRS-1:0]  air_q;      // neighbor is air or outside the chunk
  logic [FC_W-1:0]      fc_q;

  logic                 out_vld_q;
  logic                 out_last_q;
  logic                 out_vis_q;
  logic [CX_W-1:0]      out_x_q;
  logic [CY_W-1:0]      out_y_q;
  logic [CZ_W-1:0]      out_z_q;
  logic [DIR_W-1:0]     out_dir_q;
  logic [TC_W-1:0]      out_tx_q;
  logic [TC_W-1:0]      out_ty_q;
  logic [FC_W-1:0]      out_fn_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Block store: one write port, one registered read port.
  logic [TYPE_W-1:0] mem [CELL_COUNT];
  logic [TYPE_W-1:0] mem_rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [TYPE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  // Read address generation for the cell and its neighbors.
  logic [DIR_W-1:0]  rd_dir;
  logic              rd_inch;
  logic              wr_inch;

  always_comb begin
    int nx, ny, nz;
    rd_dir = DIR_W'(rd_q - 3'd1);
    nx = int'(x_q);
    ny = int'(y_q);
    nz = int'(z_q);
    if (rd_q != 3'd0) begin
      nx = nx + step_dx(rd_dir);
      ny = ny + step_dy(rd_dir);
      nz = nz + step_dz(rd_dir);
    end
    rd_inch   = in_chunk(nx, ny, nz);
    mem_raddr = cell_addr(nx, ny, nz);
    mem_re    = (state_q == S_READ);
  end

  // Writes come from the clearing sweep or from an accepted write transaction.
  always_comb begin
    wr_inch = in_chunk(int'(in_x), int'(in_y), int'(in_z));
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = in_acc && (in_kind == KIND_WRITE) && wr_inch;
      mem_waddr = cell_addr(int'(in_x), int'(in_y), int'(in_z));
      mem_wdata = in_type;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // Face selection: the lowest pending direction goes out first.
  logic [NUM_DIRS-1:0] face_mask;
  logic [DIR_W-1:0]    sel_dir;
  logic [NUM_DIRS-1:0] rem_mask;
  logic [TILE_W-1:0]   self_tiles;
  logic [7:0]          sel_tile;
  logic                out_free;
  logic [FC_W-1:0]     fc_inc;

  always_comb begin
    face_mask = (self_q != '0) ? air_q : '0;
    sel_dir   = DIR_PX;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (face_mask[i]) begin
        sel_dir = DIR_W'(i);
      end
    end
    rem_mask   = face_mask & ~(NUM_DIRS'(1) << sel_dir);
    self_tiles = tiles[self_q];
    case (sel_dir)
      DIR_PY:  sel_tile = self_tiles[7:0];
      DIR_NY:  sel_tile = self_tiles[23:16];
      default: sel_tile = self_tiles[15:8];
    endcase
    out_free = !out_vld_q || m_axis_tready;
    fc_inc   = (fc_q < FACE_MAX) ? fc_q + FC_W'(1) : fc_q;
  end

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      rd_q      <= '0;
      cap_vld_q <= 1'b0;
      fc_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cap_vld_q  <= (state_q == S_READ);
      cap_idx_q  <= rd_q;
      cap_inch_q <= rd_inch;
      if (cap_vld_q) begin
        if (cap_idx_q == 3'd0) begin
          self_q <= cap_inch_q ? mem_rdata_q : '0;
        end else begin
          air_q[cap_idx_q - 3'd1] <= !cap_inch_q || (mem_rdata_q == '0);
        end
      end

      // A taken result is dropped unless the next one replaces it in the same cycle.
      if (out_vld_q && m_axis_tready && !((state_q == S_EMIT) && out_free)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(CELL_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_kind == KIND_BEGIN) begin
              fc_q <= '0;
            end else if (in_kind == KIND_MESH) begin
              x_q     <= in_x;
              y_q     <= in_y;
              z_q     <= in_z;
              rd_q    <= '0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          rd_q <= rd_q + 3'd1;
          if (rd_q == 3'(NUM_DIRS)) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_fn_q  <= fc_q;
            out_x_q   <= x_q;
            out_y_q   <= y_q;
            out_z_q   <= z_q;
            if (face_mask == '0) begin
              // Air, outside the chunk or fully hidden: one empty result.
              out_vis_q  <= 1'b0;
              out_last_q <= 1'b1;
              out_dir_q  <= DIR_PX;
              out_tx_q   <= '0;
              out_ty_q   <= '0;
              state_q    <= S_IDLE;
            end else begin
              out_vis_q      <= 1'b1;
              out_last_q     <= (rem_mask == '0);
              out_dir_q      <= sel_dir;
              out_tx_q       <= sel_tile[3:0];
              out_ty_q       <= sel_tile[7:4];
              fc_q           <= fc_inc;
              air_q[sel_dir] <= 1'b0;
              if (rem_mask == '0) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_vis_q;
  assign m_axis_tdata  = {(OUT_DW - 46)'(0), out_fn_q, out_ty_q, out_tx_q, out_dir_q,
                          out_z_q, out_y_q, out_x_q};

  // An empty result is always the final one of its mesh transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("empty result without tlast");

  // The face counter saturates and never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fc_q <= FACE_MAX)
    else $error("face counter beyond limit");

  // All neighbor reads are captured before faces are selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !cap_vld_q)
    else $error("emitting while a read is outstanding");

  // No input transaction is taken during the clearing sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !$past(in_acc))
    else $error("input accepted during store clear");

endmodule
